FILE: design/ate_pkg.sv
`default_nettype none
package ate_pkg;

    // request codes
    typedef enum logic [3:0] {
        OP_APPEND  = 4'd0,
        OP_INSERT  = 4'd1,
        OP_DELETE  = 4'd2,
        OP_GET     = 4'd3,
        OP_SET     = 4'd4,
        OP_LSEARCH = 4'd5,
        OP_BSEARCH = 4'd6,
        OP_MAX     = 4'd7,
        OP_MIN     = 4'd8,
        OP_SUM     = 4'd9,
        OP_REVERSE = 4'd10,
        OP_SORTED  = 4'd11
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_RD,
        S_USE,
        S_RV_A,
        S_RV_B,
        S_WRV,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op                operation;
        logic [5:0]         position;
        logic signed [31:0] operand;
    } t_in_item;

    typedef struct packed {
        logic               status;
        logic signed [31:0] result_value;
        logic [4:0]         result_index;
        logic [5:0]         fill_count;
    } t_out_item;

    localparam logic [5:0] CAP_RESET = 6'd32;

endpackage
`default_nettype wire

FILE: design/ate_mem.sv
`default_nettype none
module ate_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [31:0]   i_wr_data,
    output logic [31:0]        o_rd_data
);
    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule
`default_nettype wire

FILE: design/ate_core.sv
`default_nettype none
module ate_core #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int CW    = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [5:0]       i_cfg_cap,
    input  wire logic             i_start,
    input  ate_pkg::t_in_item     i_item,
    output logic                  o_busy,
    output logic                  o_done,
    output ate_pkg::t_out_item    o_res,
    input  wire logic             i_res_take,
    output logic                  o_rd_en,
    output logic [AW-1:0]         o_rd_addr,
    output logic                  o_wr_en,
    output logic [AW-1:0]         o_wr_addr,
    output logic [31:0]           o_wr_data,
    input  wire logic [31:0]      i_rd_data
);
    import ate_pkg::*;

    localparam int XW = (CW > 6) ? CW + 1 : 7;
    localparam logic signed [CW:0] ONE_S = (CW+1)'(1);

    t_state             r_state, n_state;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [5:0]         r_cap;
    t_op                r_op, n_op;
    logic [5:0]         r_pos, n_pos;
    logic signed [31:0] r_val, n_val;
    logic [CW-1:0]      r_i, n_i;
    logic [CW-1:0]      r_j, n_j;
    logic signed [CW:0] r_lo, n_lo;
    logic signed [CW:0] r_hi, n_hi;
    logic signed [31:0] r_acc, n_acc;
    logic [31:0]        r_tmp, n_tmp;
    logic               r_status, n_status;
    logic signed [31:0] r_rval, n_rval;
    logic [4:0]         r_ridx, n_ridx;

    logic [XW-1:0]      w_eff;
    logic               w_room, w_pos_ok, w_more, w_gt, w_eq, w_take;
    logic [CW+1:0]      w_sum;
    logic [CW-1:0]      w_mid;
    logic [CW-1:0]      w_rd_idx;
    logic signed [31:0] w_rd;

    // effective limit and bounds checks
    assign w_eff    = (XW'(r_cap) > XW'(DEPTH)) ? XW'(DEPTH) : XW'(r_cap);
    assign w_room   = XW'(r_cnt) < w_eff;
    assign w_pos_ok = XW'(r_pos) < XW'(r_cnt);
    assign w_sum    = (CW+2)'(r_lo) + (CW+2)'(r_hi);
    assign w_mid    = w_sum[CW:1];
    assign w_rd     = $signed(i_rd_data);
    assign w_gt     = w_rd > r_val;
    assign w_eq     = w_rd == r_val;
    assign w_take   = (r_i == '0) ||
                      ((r_op == OP_MAX) ? (w_rd > r_acc) : (r_acc > w_rd));

    // loop condition and read index for the walk step
    always_comb begin
        w_more   = 1'b0;
        w_rd_idx = r_i;
        case (r_op) inside
            OP_INSERT: begin
                w_more   = XW'(r_i) > XW'(r_pos);
                w_rd_idx = r_i - 1'b1;
            end
            OP_SORTED: begin
                w_more   = r_i != '0;
                w_rd_idx = r_i - 1'b1;
            end
            OP_DELETE: begin
                w_more   = ((CW+1)'(r_i) + 1'b1) < (CW+1)'(r_cnt);
                w_rd_idx = r_i + 1'b1;
            end
            OP_BSEARCH: begin
                w_more   = r_lo <= r_hi;
                w_rd_idx = w_mid;
            end
            OP_REVERSE: w_more = r_i < r_j;
            OP_LSEARCH, OP_MAX, OP_MIN, OP_SUM: w_more = r_i < r_cnt;
            default: w_more = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_start) n_state = S_START;
            S_START: begin
                case (r_op) inside
                    OP_INSERT:  n_state = (w_pos_ok && w_room) ? S_RD : S_DONE;
                    OP_SORTED:  n_state = w_room ? S_RD : S_DONE;
                    OP_DELETE:  n_state = w_pos_ok ? S_RD : S_DONE;
                    OP_GET:     n_state = w_pos_ok ? S_USE : S_DONE;
                    OP_MAX, OP_MIN: n_state = (r_cnt != '0) ? S_RD : S_DONE;
                    OP_LSEARCH, OP_BSEARCH, OP_SUM, OP_REVERSE: n_state = S_RD;
                    default:    n_state = S_DONE;
                endcase
            end
            S_RD: begin
                if (w_more) begin
                    n_state = S_USE;
                end else if (r_op == OP_INSERT || r_op == OP_SORTED) begin
                    n_state = S_WRV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_USE: begin
                case (r_op) inside
                    OP_GET:     n_state = S_DONE;
                    OP_SORTED:  n_state = w_gt ? S_RD : S_WRV;
                    OP_LSEARCH, OP_BSEARCH: n_state = w_eq ? S_DONE : S_RD;
                    OP_REVERSE: n_state = S_RV_A;
                    default:    n_state = S_RD;
                endcase
            end
            S_RV_A: n_state = S_RV_B;
            S_RV_B: n_state = S_RD;
            S_WRV:  n_state = S_DONE;
            S_DONE: if (i_res_take) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory port control
    always_comb begin
        n_cnt = r_cnt;   n_op = r_op;     n_pos = r_pos;  n_val = r_val;
        n_i = r_i;       n_j = r_j;       n_lo = r_lo;    n_hi = r_hi;
        n_acc = r_acc;   n_tmp = r_tmp;   n_status = r_status;
        n_rval = r_rval; n_ridx = r_ridx;
        o_rd_en = 1'b0;  o_rd_addr = '0;
        o_wr_en = 1'b0;  o_wr_addr = '0;  o_wr_data = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op  = i_item.operation;
                    n_pos = i_item.position;
                    n_val = i_item.operand;
                end
            end
            S_START: begin
                n_status = 1'b1;
                n_rval   = '0;
                n_ridx   = '0;
                n_i      = '0;
                n_acc    = '0;
                case (r_op) inside
                    OP_APPEND: begin
                        if (w_room) begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = AW'(r_cnt);
                            o_wr_data = r_val;
                            n_cnt     = r_cnt + 1'b1;
                            n_status  = 1'b0;
                        end
                    end
                    OP_INSERT, OP_SORTED: n_i = r_cnt;
                    OP_DELETE: n_i = CW'(r_pos);
                    OP_GET: begin
                        o_rd_en   = w_pos_ok;
                        o_rd_addr = AW'(r_pos);
                    end
                    OP_SET: begin
                        if (w_pos_ok) begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = AW'(r_pos);
                            o_wr_data = r_val;
                            n_status  = 1'b0;
                        end
                    end
                    OP_BSEARCH: begin
                        n_lo = '0;
                        n_hi = $signed({1'b0, r_cnt}) - ONE_S;
                    end
                    OP_SUM: n_status = 1'b0;
                    OP_REVERSE: begin
                        // empty table: no pair to swap
                        n_j      = (r_cnt == '0) ? '0 : r_cnt - 1'b1;
                        n_status = 1'b0;
                    end
                    default: ;
                endcase
            end
            S_RD: begin
                if (w_more) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = AW'(w_rd_idx);
                    if (r_op == OP_BSEARCH) n_i = w_mid;
                end else begin
                    case (r_op) inside
                        OP_DELETE: begin
                            n_cnt    = r_cnt - 1'b1;
                            n_status = 1'b0;
                        end
                        OP_MAX, OP_MIN: begin
                            n_rval   = r_acc;
                            n_status = 1'b0;
                        end
                        OP_SUM: n_rval = r_acc;
                        default: ;
                    endcase
                end
            end
            S_USE: begin
                case (r_op) inside
                    OP_GET: begin
                        n_rval   = w_rd;
                        n_status = 1'b0;
                    end
                    OP_INSERT, OP_SORTED: begin
                        if (r_op == OP_INSERT || w_gt) begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = AW'(r_i);
                            o_wr_data = i_rd_data;
                            n_i       = r_i - 1'b1;
                        end
                    end
                    OP_DELETE: begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = AW'(r_i);
                        o_wr_data = i_rd_data;
                        n_i       = r_i + 1'b1;
                    end
                    OP_LSEARCH: begin
                        if (w_eq) begin
                            n_ridx   = 5'(r_i);
                            n_status = 1'b0;
                        end else begin
                            n_i = r_i + 1'b1;
                        end
                    end
                    OP_BSEARCH: begin
                        if (w_eq) begin
                            n_ridx   = 5'(r_i);
                            n_status = 1'b0;
                        end else if (w_rd > r_val) begin
                            n_hi = $signed({1'b0, r_i}) - ONE_S;
                        end else begin
                            n_lo = $signed({1'b0, r_i}) + ONE_S;
                        end
                    end
                    OP_MAX, OP_MIN: begin
                        if (w_take) n_acc = w_rd;
                        n_i = r_i + 1'b1;
                    end
                    OP_SUM: begin
                        n_acc = r_acc + w_rd;
                        n_i   = r_i + 1'b1;
                    end
                    OP_REVERSE: begin
                        n_tmp     = i_rd_data;
                        o_rd_en   = 1'b1;
                        o_rd_addr = AW'(r_j);
                    end
                    default: ;
                endcase
            end
            S_RV_A: begin
                o_wr_en   = 1'b1;
                o_wr_addr = AW'(r_i);
                o_wr_data = i_rd_data;
            end
            S_RV_B: begin
                o_wr_en   = 1'b1;
                o_wr_addr = AW'(r_j);
                o_wr_data = r_tmp;
                n_i       = r_i + 1'b1;
                n_j       = r_j - 1'b1;
            end
            S_WRV: begin
                o_wr_en   = 1'b1;
                o_wr_addr = AW'(r_i);
                o_wr_data = r_val;
                n_cnt     = r_cnt + 1'b1;
                n_status  = 1'b0;
            end
            S_DONE: ;
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_cap   <= CAP_RESET;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_we) r_cap <= i_cfg_cap;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_op <= n_op;     r_pos <= n_pos;   r_val <= n_val;
        r_i <= n_i;       r_j <= n_j;       r_lo <= n_lo;   r_hi <= n_hi;
        r_acc <= n_acc;   r_tmp <= n_tmp;   r_status <= n_status;
        r_rval <= n_rval; r_ridx <= n_ridx;
    end

    assign o_busy = r_state != S_IDLE;
    assign o_done = r_state == S_DONE;
    assign o_res  = '{status: r_status, result_value: r_rval,
                      result_index: r_ridx, fill_count: 6'(r_cnt)};
endmodule
`default_nettype wire

FILE: design/array_table_engine_top.sv
//  channel | direction | handshake                    | beat
//  in      | input     | i_in_valid / o_in_stall      | t_in_item
//  out     | output    | o_out_valid / i_out_stall    | t_out_item
//  cfg     | input     | i_cfg_valid / o_cfg_ready    | capacity, 6 bits
//
//  One request at a time; the sequencer walks the table one entry per read
//  of the RAM's single read port.  Get, set and append need no walk;
//  shifts, searches and reductions visit the entries one by one, and
//  reverse swaps one pair of entries at a time.
//  Reset (synchronous, active low) empties the table and sets capacity 32.
//  A finished result waits in the output register while the out side stalls.
`default_nettype none
module array_table_engine_top #(
    parameter int DEPTH = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  ate_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output ate_pkg::t_out_item o_out_data,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [5:0]    i_cfg_data
);
    import ate_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic          w_busy, w_done, w_take, w_start;
    t_out_item     w_res;
    logic          w_rd_en, w_wr_en;
    logic [AW-1:0] w_rd_addr, w_wr_addr;
    logic [31:0]   w_wr_data, w_rd_data;
    logic          r_out_valid;
    t_out_item     r_out_data;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_busy;
    assign w_start     = i_in_valid && !w_busy;
    assign w_take      = !r_out_valid || !i_out_stall;

    ate_core #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_cap  (i_cfg_data),
        .i_start    (w_start),
        .i_item     (i_in_data),
        .o_busy     (w_busy),
        .o_done     (w_done),
        .o_res      (w_res),
        .i_res_take (w_take),
        .o_rd_en    (w_rd_en),
        .o_rd_addr  (w_rd_addr),
        .o_wr_en    (w_wr_en),
        .o_wr_addr  (w_wr_addr),
        .o_wr_data  (w_wr_data),
        .i_rd_data  (w_rd_data)
    );

    ate_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done && w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done && w_take) r_out_data <= w_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // checks
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.status) |->
        (r_out_data.result_value == '0 && r_out_data.result_index == '0))
        else $error("rejected beat carries nonzero value or index");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("core not busy after accepting a request");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && r_out_valid && i_out_stall) |=> (w_done && $stable(w_res)))
        else $error("finished result dropped while output stalled");
endmodule
`default_nettype wire
